// ===== rtl/core/rmez_pkg.sv =====
package rmez_pkg;

   localparam int CordicStagesDefault = 16;
   localparam int AngTableLen = 24;
   localparam int InW = 16;
   localparam int CW = 17;
   localparam int SumW = 32;
   localparam int XyW = 36;
   localparam int ZW = 34;
   localparam int ThrW = 15;
   localparam int SqW = 17;

   localparam logic signed [ZW-1:0] PiQ30 = 34'sd3373259426;

   localparam logic [0:0] CSR_GIMBAL_THRESHOLD = 1'b0;

   typedef struct packed {
      logic signed [15:0] r00;
      logic signed [15:0] r10;
      logic signed [15:0] r11;
      logic signed [15:0] r12;
      logic signed [15:0] r20;
      logic signed [15:0] r21;
      logic signed [15:0] r22;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] yaw;
      logic signed [15:0] pitch;
      logic signed [15:0] roll;
      logic               gimbal_lock;
   } rsp_payload_type;

   // one CORDIC vectoring lane
   typedef struct packed {
      logic signed [XyW-1:0] x;
      logic signed [XyW-1:0] y;
      logic signed [ZW-1:0]  z;
      logic                  zero;
   } lane_type;

   function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
      logic signed [ZW-1:0] r;
      begin
         case (i)
            5'd0: r = 34'sd843314856;
            5'd1: r = 34'sd497837829;
            5'd2: r = 34'sd263043836;
            5'd3: r = 34'sd133525158;
            5'd4: r = 34'sd67021686;
            5'd5: r = 34'sd33543515;
            5'd6: r = 34'sd16775850;
            5'd7: r = 34'sd8388437;
            5'd8: r = 34'sd4194282;
            5'd9: r = 34'sd2097149;
            5'd10: r = 34'sd1048575;
            5'd11: r = 34'sd524287;
            5'd12: r = 34'sd262143;
            5'd13: r = 34'sd131071;
            5'd14: r = 34'sd65535;
            5'd15: r = 34'sd32767;
            5'd16: r = 34'sd16383;
            5'd17: r = 34'sd8191;
            5'd18: r = 34'sd4095;
            5'd19: r = 34'sd2047;
            5'd20: r = 34'sd1023;
            5'd21: r = 34'sd511;
            5'd22: r = 34'sd255;
            5'd23: r = 34'sd127;
            default: r = '0;
         endcase
         return r;
      end
   endfunction

   // start a lane: scale, fold left half-plane into right
   function automatic lane_type lane_init(input logic signed [CW-1:0] y,
                                          input logic signed [CW-1:0] x);
      lane_type l;
      logic signed [XyW-1:0] xs;
      logic signed [XyW-1:0] ys;
      begin
         xs = {{(XyW-CW-16){x[CW-1]}}, x, 16'd0};
         ys = {{(XyW-CW-16){y[CW-1]}}, y, 16'd0};
         l.zero = (x == '0) && (y == '0);
         if (x < 0) begin
            l.x = -xs;
            l.y = -ys;
            l.z = (y >= 0) ? PiQ30 : -PiQ30;
         end else begin
            l.x = xs;
            l.y = ys;
            l.z = '0;
         end
         return l;
      end
   endfunction

   function automatic logic signed [15:0] lane_round(input lane_type l);
      logic signed [ZW-1:0] a;
      logic signed [ZW-1:0] r;
      begin
         a = l.z[ZW-1] ? -l.z : l.z;
         r = (a + 34'sd65536) >>> 17;
         if (l.zero) return '0;
         return l.z[ZW-1] ? -r[15:0] : r[15:0];
      end
   endfunction

endpackage

// ===== rtl/core/rmez_isqrt_cell.sv =====
// one bit of a restoring square root: one result bit per cell
module rmez_isqrt_cell #(
   parameter int Bit = 0
) (
   input  logic                           clock,
   input  logic                           enable,
   input  logic [rmez_pkg::SumW-1:0]      rem_in,
   input  logic [rmez_pkg::SqW-1:0]       root_in,
   output logic [rmez_pkg::SumW-1:0]      rem_out,
   output logic [rmez_pkg::SqW-1:0]       root_out
);
   import rmez_pkg::*;

   logic [SumW+1:0] trial;
   logic [SumW+1:0] rem_w;
   logic [SumW-1:0] rem_ff, rem_in_c;
   logic [SqW-1:0]  root_ff, root_in_c;

   always_comb begin
      trial = ({{(SumW+2-SqW){1'b0}}, root_in} << (Bit + 1))
            + ({{(SumW+1){1'b0}}, 1'b1} << (2 * Bit));
      rem_w = {2'b00, rem_in};
      if (rem_w >= trial) begin
         rem_in_c  = SumW'(rem_w - trial);
         root_in_c = root_in | (SqW'(1) << Bit);
      end else begin
         rem_in_c  = rem_in;
         root_in_c = root_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in_c;
         root_ff <= root_in_c;
      end
   end

   assign rem_out  = rem_ff;
   assign root_out = root_ff;
endmodule

// ===== rtl/core/rmez_cordic_cell.sv =====
// one CORDIC micro-rotation on three lanes
module rmez_cordic_cell #(
   parameter int Stage = 0
) (
   input  logic                 clock,
   input  logic                 enable,
   input  rmez_pkg::lane_type   lane_in [3],
   output rmez_pkg::lane_type   lane_out [3]
);
   import rmez_pkg::*;

   lane_type nxt [3];
   lane_type lane_ff [3];
   logic signed [XyW-1:0] xs, ys;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         xs = lane_in[k].x >>> Stage;
         ys = lane_in[k].y >>> Stage;
         nxt[k] = lane_in[k];
         if (!lane_in[k].y[XyW-1]) begin
            nxt[k].x = lane_in[k].x + ys;
            nxt[k].y = lane_in[k].y - xs;
            nxt[k].z = lane_in[k].z + atan_q30(5'(Stage));
         end else begin
            nxt[k].x = lane_in[k].x - ys;
            nxt[k].y = lane_in[k].y + xs;
            nxt[k].z = lane_in[k].z - atan_q30(5'(Stage));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) lane_ff <= nxt;
   end

   assign lane_out = lane_ff;
endmodule

// ===== rtl/core/rotation_matrix_to_euler_zyx.sv =====
// Rotation matrix to Z-Y-X Euler angles.
// Request channel (req_*): seven Q1.14 matrix elements, taken when
// req_valid is high and req_stall is low. Result channel (rsp_*): yaw,
// pitch, roll in Q2.13 radians plus the gimbal-lock flag.
// The pipeline is a row of cells: 17 square-root cells form
// c = floor(sqrt(r00^2+r10^2)) one bit per cell, one cell registers the
// squares, one cell picks the branch and seeds three CORDIC lanes, and
// CORDIC_STAGES rotation cells run all three atan2 lanes side by side.
// That is CORDIC_STAGES + 20 register stages including the output
// register (stage counts above 24 act as 24); one request enters
// every cycle while the row is not held. The whole row advances as
// one: when the output register is full and the receiver stalls, the
// row holds, and req_stall rises. A request that comes in at that
// moment waits. Reset clears the valid bits of every cell and sets
// gimbal_threshold to 1; CSR writes go through the APB-style port at
// byte address 0.
module rotation_matrix_to_euler_zyx #(
   parameter int CORDIC_STAGES = rmez_pkg::CordicStagesDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  rmez_pkg::req_payload_type   req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output rmez_pkg::rsp_payload_type   rsp_payload,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [0:0]                  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import rmez_pkg::*;

   localparam int NStg = (CORDIC_STAGES > AngTableLen) ? AngTableLen : CORDIC_STAGES;
   localparam int Depth = 2 + SqW + NStg;

   // CSR
   logic [ThrW-1:0] thr_ff;
   assign pready = 1'b1;
   assign prdata = (paddr == CSR_GIMBAL_THRESHOLD) ? {17'd0, thr_ff} : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) thr_ff <= ThrW'(1);
      else if (psel && penable && pwrite && pready && paddr == CSR_GIMBAL_THRESHOLD)
         thr_ff <= pwdata[ThrW-1:0];
   end

   // row control: advance everything when output can take a result
   logic adv;
   logic [Depth-1:0] vld_ff;
   assign adv = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[Depth-2:0], req_valid};
   end

   // payload carried alongside the square-root cells
   req_payload_type mat_ff [SqW+1];
   logic [SumW-1:0] sq_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         mat_ff[0] <= req_payload;
         sq_ff <= SumW'(32'(req_payload.r00 * req_payload.r00))
                + SumW'(32'(req_payload.r10 * req_payload.r10));
         for (int k = 1; k <= SqW; k++) mat_ff[k] <= mat_ff[k-1];
      end
   end

   logic [SumW-1:0] rem_w [SqW+1];
   logic [SqW-1:0]  root_w [SqW+1];
   assign rem_w[0]  = sq_ff;
   assign root_w[0] = '0;
   for (genvar b = 0; b < SqW; b++) begin : g_sq
      rmez_isqrt_cell #(.Bit(SqW-1-b)) u_cell (
         .clock(clock), .enable(adv),
         .rem_in(rem_w[b]), .root_in(root_w[b]),
         .rem_out(rem_w[b+1]), .root_out(root_w[b+1])
      );
   end

   // branch select and lane seeding
   req_payload_type m;
   logic [SqW-1:0] c;
   logic lock;
   lane_type seed [3];
   assign m = mat_ff[SqW];
   assign c = root_w[SqW];
   assign lock = c < {2'b00, thr_ff};
   always_comb begin
      seed[0] = lane_init(-CW'(m.r20), $signed(c));
      seed[1] = lock ? lane_init(-CW'(m.r12), CW'(m.r11))
                     : lane_init(CW'(m.r21), CW'(m.r22));
      seed[2] = lane_init(CW'(m.r10), CW'(m.r00));
   end

   lane_type seed_ff [3];
   lane_type lanes [NStg+1][3];
   logic lock_sr_ff [NStg+1];
   always_ff @(posedge clock) begin
      if (adv) begin
         seed_ff <= seed;
         lock_sr_ff[0] <= lock;
         for (int k = 1; k <= NStg; k++) lock_sr_ff[k] <= lock_sr_ff[k-1];
      end
   end
   assign lanes[0] = seed_ff;

   for (genvar s = 0; s < NStg; s++) begin : g_cr
      rmez_cordic_cell #(.Stage(s)) u_cell (
         .clock(clock), .enable(adv),
         .lane_in(lanes[s]), .lane_out(lanes[s+1])
      );
   end

   // output register
   rsp_payload_type out_ff;
   logic out_vld_ff;
   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (adv) out_vld_ff <= vld_ff[Depth-1];
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff.pitch <= lane_round(lanes[NStg][0]);
         out_ff.roll <= lane_round(lanes[NStg][1]);
         out_ff.yaw <= lock_sr_ff[NStg] ? 16'sd0 : lane_round(lanes[NStg][2]);
         out_ff.gimbal_lock <= lock_sr_ff[NStg];
      end
   end
   assign rsp_valid = out_vld_ff;
   assign rsp_payload = out_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result dropped under stall");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("row held without receiver stall");
   a_yaw: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.gimbal_lock |-> rsp_payload.yaw == 16'sd0)
      else $error("yaw not zero in gimbal lock");
endmodule
